### design/icy_pkg.sv
// ----------------------------------------------------------------------------
// icy_pkg: shared types and constants for the ICY metadata deframer
// Byte kind codes, field widths and the length byte scaling.
// ----------------------------------------------------------------------------
package icy_pkg;

    localparam int BYTE_W     = 8;
    localparam int INTERVAL_W = 16;
    localparam int COUNT_W    = 16;
    localparam int LENGTH_W   = 12;
    localparam int KIND_W     = 2;

    // Length byte counts blocks of sixteen bytes
    localparam int LENGTH_SHIFT = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_AUDIO  = 2'd0,
        KIND_META   = 2'd1,
        KIND_LENGTH = 2'd2
    } t_kind;

endpackage

### design/icy_metadata_deframer.sv
// ----------------------------------------------------------------------------
// icy_metadata_deframer: splits in-band ICY metadata from an audio stream
// One byte in, one tagged byte out: audio, metadata (with last flag) or the
// metadata length byte. A zero interval passes every byte through as audio.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_byte
//  out     | output    | o_out_valid / i_out_ready | o_out_byte, o_byte_kind,
//          |           |                           | o_meta_last
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (meta interval)
//
//  One byte per cycle when not stalled; the result appears in the output register
//  in the cycle after the byte is taken. The framing state is updated as the byte
//  is taken. A stall on the output holds the result; a new byte is still taken in
//  the cycle the held result leaves. Reset is synchronous, active low; it clears
//  the interval register, the framing state and the output valid flag.
// ----------------------------------------------------------------------------
module icy_metadata_deframer
    import icy_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BYTE_W-1:0]     i_in_byte,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic [KIND_W-1:0]     o_byte_kind,
    output logic                  o_meta_last,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [INTERVAL_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        PH_AUDIO  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_META   = 2'd2
    } t_phase;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    t_phase                r_phase,       n_phase;
    logic [COUNT_W-1:0]    r_byte_count,  n_byte_count;
    logic [LENGTH_W-1:0]   r_meta_length, n_meta_length;
    logic [INTERVAL_W-1:0] r_meta_interval;

    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;
    t_kind                 r_kind,        n_kind;
    logic                  r_last,        n_last;

    logic                  in_take;
    logic [COUNT_W-1:0]    count_inc;
    logic [LENGTH_W-1:0]   length_new;

    // Handshakes: output register frees up as it drains
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_in_valid && o_in_ready;

    // Saturating count and the length byte scaled by sixteen
    assign count_inc  = (r_byte_count == COUNT_MAX) ? COUNT_MAX : r_byte_count + 1'b1;
    assign length_new = {i_in_byte, {LENGTH_SHIFT{1'b0}}};

    // Framing decision for the arriving byte
    always_comb begin
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_meta_length = r_meta_length;
        n_kind        = KIND_AUDIO;
        n_last        = 1'b0;
        if (r_meta_interval != '0) begin
            unique case (r_phase)
                PH_LENGTH: begin
                    n_kind        = KIND_LENGTH;
                    n_meta_length = length_new;
                    n_byte_count  = '0;
                    n_phase       = (length_new != '0) ? PH_META : PH_AUDIO;
                end
                PH_META: begin
                    n_kind       = KIND_META;
                    n_byte_count = count_inc;
                    if (count_inc >= COUNT_W'(r_meta_length)) begin
                        n_last       = 1'b1;
                        n_byte_count = '0;
                        n_phase      = PH_AUDIO;
                    end
                end
                default: begin
                    // audio phase; interval may have been lowered below the count
                    if (r_byte_count >= r_meta_interval) begin
                        n_kind        = KIND_LENGTH;
                        n_meta_length = length_new;
                        n_byte_count  = '0;
                        n_phase       = (length_new != '0) ? PH_META : PH_AUDIO;
                    end else begin
                        n_kind       = KIND_AUDIO;
                        n_byte_count = count_inc;
                        n_phase      = (count_inc >= r_meta_interval) ? PH_LENGTH : PH_AUDIO;
                    end
                end
            endcase
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_AUDIO;
            r_byte_count    <= '0;
            r_meta_length   <= '0;
            r_meta_interval <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_meta_interval <= i_cfg_data;
            end
            if (in_take) begin
                r_phase       <= n_phase;
                r_byte_count  <= n_byte_count;
                r_meta_length <= n_meta_length;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_byte <= i_in_byte;
            r_kind     <= n_kind;
            r_last     <= n_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_byte_kind = r_kind;
    assign o_meta_last = r_last;

endmodule

### design/icy_checker.sv
// ----------------------------------------------------------------------------
// icy_checker: port-level checks for the ICY metadata deframer
// Watches the top level's ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module icy_checker
    import icy_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [KIND_W-1:0] o_byte_kind,
    input logic              o_meta_last
);

    // Every taken byte produces a word on the next cycle
    a_take_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("taken byte gave no output word");

    // An empty output register never refuses input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input refused with output register empty");

    // Last flag only on metadata bytes
    a_last_on_meta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_meta_last) |-> (o_byte_kind == KIND_META))
        else $error("last flag on a non-metadata word");

    // Held word stays valid while stalled
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output word dropped while stalled");

endmodule

bind icy_metadata_deframer icy_checker u_icy_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_byte_kind (o_byte_kind),
    .o_meta_last (o_meta_last)
);
